// ===== hdl/swdik_pkg.sv =====
// Shared types, constants and tables for the swerve drive inverse kinematics block.
// Depends on nothing; used by the top level and the speed scaler.
package swdik_pkg;

    localparam int TURN_UNITS    = 25000;
    localparam int HALF_UNITS    = 12500;
    localparam int QUARTER_UNITS = 6250;
    localparam int ANG_HALF      = 8388608;
    localparam int ANG_FULL      = 16777216;

    localparam logic [2:0] REG_OFFSET_X = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y = 3'd1;
    localparam logic [2:0] REG_RPM      = 3'd2;
    localparam logic [2:0] REG_MID_FL   = 3'd3;
    localparam logic [2:0] REG_MID_RL   = 3'd4;
    localparam logic [2:0] REG_MID_RR   = 3'd5;
    localparam logic [2:0] REG_MID_FR   = 3'd6;

    localparam int PROD_W = 41;
    localparam int QUOT_W = 14;

    // The speed scale 256000000 is 2^14 times 15625; the quotient by 15625 is
    // exact for every 27-bit numerator with this reciprocal and a shift by 41.
    localparam int SPEED_SHIFT = 14;
    localparam int RECIP_IN_W  = PROD_W - SPEED_SHIFT;
    localparam int RECIP_W     = 28;
    localparam int RECIP_SHIFT = 41;
    localparam logic [RECIP_W-1:0] SPEED_RECIP = 28'd140737489;

    typedef logic signed [14:0] pos_t;
    typedef logic signed [16:0] unit_t;
    typedef logic signed [26:0] cvec_t;

    typedef struct packed {
        logic                start;
        logic [PROD_W-1:0]   dividend;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [QUOT_W-1:0]   quotient;
    } div_rsp_t;

    function automatic logic [21:0] atan_val(input logic [4:0] i);
        logic [21:0] r;
        case (i)
            5'd0:    r = 22'd2097152;
            5'd1:    r = 22'd1238021;
            5'd2:    r = 22'd654136;
            5'd3:    r = 22'd332050;
            5'd4:    r = 22'd166669;
            5'd5:    r = 22'd83416;
            5'd6:    r = 22'd41718;
            5'd7:    r = 22'd20860;
            5'd8:    r = 22'd10430;
            5'd9:    r = 22'd5215;
            5'd10:   r = 22'd2608;
            5'd11:   r = 22'd1304;
            5'd12:   r = 22'd652;
            5'd13:   r = 22'd326;
            5'd14:   r = 22'd163;
            5'd15:   r = 22'd81;
            5'd16:   r = 22'd41;
            5'd17:   r = 22'd20;
            5'd18:   r = 22'd10;
            5'd19:   r = 22'd5;
            5'd20:   r = 22'd3;
            5'd21:   r = 22'd1;
            5'd22:   r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

    function automatic unit_t wrap_turn(input unit_t v);
        unit_t r;
        if (v > 17'sd12500)
            r = v - 17'sd25000;
        else if (v < -17'sd12500)
            r = v + 17'sd25000;
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== hdl/swerve_drive_inverse_kinematics_top.sv =====
// Top level of the four-wheel swerve drive inverse kinematics block.
// Depends on swdik_pkg and swdik_divider.
//
// Channel   Direction  Width  Contents
// s_*       in         104    chassis velocity and four measured steering positions
// m_*       out        120    four steering targets and four drive commands
// cfg_*     in         16     offsets, rpm ratio, four steering middles
//
// After an item is accepted, the sequencer forms the products, then for each wheel the
// vector, the squaring states S_SQ1 and S_SQ2, 25 square root steps in S_ITER (the first
// CORDIC_STEPS of them also CORDIC steps), angle, target and the speed scaling, and then
// loads the output register. The next item can be accepted in the cycle m_tvalid rises.
// s_tready is high only while the sequencer is idle; a result waits in the output
// register while the next item is taken, and the sequencer holds before writing it.
// Reset clears the control state, the configuration registers and the stored steering targets.
module swerve_drive_inverse_kinematics_top
    import swdik_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vel_x, vel_y, yaw_rate, pos_front_left, pos_rear_left, pos_rear_right,
    // pos_front_right, zero fill
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // angle_front_left, angle_rear_left, angle_rear_right, angle_front_right,
    // speed_front_left, speed_rear_left, speed_rear_right, speed_front_right
    output logic [119:0] m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam logic [4:0] N_IT    = 5'(CORDIC_STEPS);
    localparam logic [4:0] SQ_LAST = 5'd24;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_VEC  = 4'd2;
    localparam logic [3:0] S_SQ1  = 4'd3;
    localparam logic [3:0] S_SQ2  = 4'd4;
    localparam logic [3:0] S_ITER = 4'd5;
    localparam logic [3:0] S_ANG  = 4'd6;
    localparam logic [3:0] S_TGT  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]         state_reg;
    logic [10:0]        ox_reg, oy_reg;
    logic [15:0]        rpm_reg;
    pos_t               mid_reg [4];
    logic signed [15:0] last_reg [4];

    logic signed [12:0] vx_reg, vy_reg, w_reg;
    pos_t               pos_reg [4];
    logic signed [22:0] vxk_reg, vyk_reg;
    logic signed [24:0] wx_reg, wy_reg;
    logic               still_reg;
    logic [1:0]         wheel_reg;
    logic [4:0]         cnt_reg;
    logic signed [24:0] ax_reg, ay_reg;
    cvec_t              x_reg, y_reg, z_reg;
    logic               zero_reg;
    logic [49:0]        n_reg, res_reg;
    logic signed [15:0] ang_reg;
    logic               rev_reg;
    logic [14:0]        angle_res [4];
    logic [14:0]        speed_res [4];
    logic               m_tvalid_reg;
    logic [119:0]       m_tdata_reg;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic signed [24:0] ax_next, ay_next;
    logic signed [49:0] sq_a, sq_b;
    cvec_t              xs, ys, zw;
    logic [49:0]        sq_bit, sq_trial;
    logic signed [42:0] ang_prod;
    unit_t              t1, diff, t2, t3;
    logic               rev_next;
    logic [14:0]        spd;

    always_comb
    begin
        ax_next = (wheel_reg == 2'd1 || wheel_reg == 2'd2)
                  ? 25'({{2{vxk_reg[22]}}, vxk_reg} - wy_reg)
                  : 25'({{2{vxk_reg[22]}}, vxk_reg} + wy_reg);
        ay_next = (wheel_reg[1])
                  ? 25'({{2{vyk_reg[22]}}, vyk_reg} - wx_reg)
                  : 25'({{2{vyk_reg[22]}}, vyk_reg} + wx_reg);
        sq_a     = ax_reg * ax_reg;
        sq_b     = ay_reg * ay_reg;
        xs       = x_reg >>> cnt_reg;
        ys       = y_reg >>> cnt_reg;
        sq_bit   = 50'd1 << {(SQ_LAST - cnt_reg), 1'b0};
        sq_trial = res_reg + sq_bit;
        if (z_reg > 27'sd8388608)
            zw = z_reg - 27'sd16777216;
        else if (z_reg <= -27'sd8388608)
            zw = z_reg + 27'sd16777216;
        else
            zw = z_reg;
        ang_prod = (43'(zw) * 43'sd25000) + 43'sd8388608;
        t1   = wrap_turn(17'(mid_reg[wheel_reg]) + 17'(ang_reg));
        diff = wrap_turn(t1 - 17'(pos_reg[wheel_reg]));
        rev_next = 1'b0;
        t2 = t1;
        if (diff > 17'sd6250)
        begin
            t2       = t1 - 17'sd12500;
            rev_next = 1'b1;
        end
        else if (diff < -17'sd6250)
        begin
            t2       = t1 + 17'sd12500;
            rev_next = 1'b1;
        end
        t3  = wrap_turn(t2);
        spd = rev_reg ? {1'b0, div_rsp.quotient} : 15'(-{1'b0, div_rsp.quotient});
    end

    assign div_req.start    = (state_reg == S_TGT);
    assign div_req.dividend = 41'(res_reg[24:0] * rpm_reg);

    swdik_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ox_reg       <= '0;
            oy_reg       <= '0;
            rpm_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            wheel_reg    <= '0;
            cnt_reg      <= '0;
            for (int i = 0; i < 4; i++)
            begin
                mid_reg[i]  <= '0;
                last_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OFFSET_X: ox_reg     <= cfg_data[10:0];
                    REG_OFFSET_Y: oy_reg     <= cfg_data[10:0];
                    REG_RPM:      rpm_reg    <= cfg_data;
                    REG_MID_FL:   mid_reg[0] <= cfg_data[14:0];
                    REG_MID_RL:   mid_reg[1] <= cfg_data[14:0];
                    REG_MID_RR:   mid_reg[2] <= cfg_data[14:0];
                    REG_MID_FR:   mid_reg[3] <= cfg_data[14:0];
                    default:      ;
                endcase
            end
            if (m_tvalid_reg && m_tready && state_reg != S_DONE)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                        state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    wheel_reg <= '0;
                    state_reg <= S_VEC;
                end
                S_VEC:
                    state_reg <= S_SQ1;
                S_SQ1:
                    state_reg <= S_SQ2;
                S_SQ2:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_ITER;
                end
                S_ITER:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == SQ_LAST)
                        state_reg <= S_ANG;
                end
                S_ANG:
                    state_reg <= S_TGT;
                S_TGT:
                begin
                    if (!still_reg)
                        last_reg[wheel_reg] <= 16'(t3);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        wheel_reg <= wheel_reg + 2'd1;
                        state_reg <= (wheel_reg == 2'd3) ? S_DONE : S_VEC;
                    end
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                vx_reg     <= s_tdata[12:0];
                vy_reg     <= s_tdata[25:13];
                w_reg      <= s_tdata[38:26];
                pos_reg[0] <= s_tdata[53:39];
                pos_reg[1] <= s_tdata[68:54];
                pos_reg[2] <= s_tdata[83:69];
                pos_reg[3] <= s_tdata[98:84];
            end
            S_MUL:
            begin
                vxk_reg   <= vx_reg * 23'sd1000;
                vyk_reg   <= vy_reg * 23'sd1000;
                wx_reg    <= w_reg * $signed({1'b0, ox_reg});
                wy_reg    <= w_reg * $signed({1'b0, oy_reg});
                still_reg <= (vx_reg == '0) && (vy_reg == '0) && (w_reg == '0);
            end
            S_VEC:
            begin
                ax_reg <= ax_next;
                ay_reg <= ay_next;
            end
            S_SQ1:
            begin
                zero_reg <= (ax_reg == '0) && (ay_reg == '0);
                if (ax_reg < 0)
                begin
                    x_reg <= -27'(ax_reg);
                    y_reg <= -27'(ay_reg);
                    z_reg <= 27'sd8388608;
                end
                else
                begin
                    x_reg <= 27'(ax_reg);
                    y_reg <= 27'(ay_reg);
                    z_reg <= '0;
                end
                n_reg <= sq_a;
            end
            S_SQ2:
            begin
                n_reg   <= n_reg + sq_b;
                res_reg <= '0;
            end
            S_ITER:
            begin
                if (cnt_reg < N_IT)
                begin
                    if (y_reg > 0)
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + $signed({5'd0, atan_val(cnt_reg)});
                    end
                    else
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - $signed({5'd0, atan_val(cnt_reg)});
                    end
                end
                if (n_reg >= sq_trial)
                begin
                    n_reg   <= n_reg - sq_trial;
                    res_reg <= (res_reg >> 1) + sq_bit;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
            end
            S_ANG:
                ang_reg <= zero_reg ? '0 : ang_prod[39:24];
            S_TGT:
            begin
                if (still_reg)
                begin
                    angle_res[wheel_reg] <= last_reg[wheel_reg][14:0];
                    rev_reg              <= 1'b0;
                end
                else
                begin
                    angle_res[wheel_reg] <= t3[14:0];
                    rev_reg              <= rev_next;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                    speed_res[wheel_reg] <= spd;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                    m_tdata_reg <= {speed_res[3], speed_res[2], speed_res[1], speed_res[0],
                                    angle_res[3], angle_res[2], angle_res[1], angle_res[0]};
            end
            default:
                ;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hdl/swdik_divider.sv =====
// Division by the fixed speed scale: a shift and a reciprocal multiplication.
// Depends on swdik_pkg for widths and the reciprocal.
module swdik_divider
    import swdik_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [RECIP_IN_W-1:0]         num_reg, num_next;
    logic [QUOT_W-1:0]             q_reg, q_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [RECIP_IN_W+RECIP_W-1:0] prod;

    always_comb
    begin
        prod      = num_reg * SPEED_RECIP;
        num_next  = num_reg;
        q_next    = q_reg;
        busy_next = 1'b0;
        done_next = 1'b0;
        if (req.start)
        begin
            num_next  = req.dividend[PROD_W-1:SPEED_SHIFT];
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next    = prod[RECIP_SHIFT +: QUOT_W];
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        q_reg   <= q_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

// ===== hdl/swdik_check.sv =====
// Port-level checker for the swerve drive inverse kinematics top level.
// Depends on the top level's ports only; bound to it at the end of this file.
module swdik_check
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata
);

    function automatic logic angles_ok(input logic [119:0] d);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            if ($signed(d[i*15 +: 15]) > 15'sd12500 || $signed(d[i*15 +: 15]) < -15'sd12500)
                ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic logic speeds_ok(input logic [119:0] d);
        logic ok;
        ok = 1'b1;
        for (int i = 4; i < 8; i++)
        begin
            if ($signed(d[i*15 +: 15]) > 15'sd8192 || $signed(d[i*15 +: 15]) < -15'sd8192)
                ok = 1'b0;
        end
        return ok;
    endfunction

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is still in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output item changed");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> angles_ok(m_tdata))
        else $error("steering target out of one turn");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> speeds_ok(m_tdata))
        else $error("drive command beyond reachable range");

endmodule

bind swerve_drive_inverse_kinematics_top swdik_check u_check
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
